// ===== hdl/sdcd_pkg.sv =====
// Shared types and constants for the switch debounce / click detector.
// No dependencies; used by sdcd_step and the top level.
package sdcd_pkg;

   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned PeriodWidth = 16;
   localparam int unsigned CsrIdxWidth = 3;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DEGLITCH_PERIOD = 3'd0,
      CSR_DEBOUNCE_PERIOD = 3'd1,
      CSR_HOLD_PERIOD     = 3'd2,
      CSR_DBL_TAP_WINDOW  = 3'd3,
      CSR_ACTIVE_LOW      = 3'd4
   } csr_index_type;

   localparam logic [PeriodWidth-1:0] DeglitchReset = 16'd10;
   localparam logic [PeriodWidth-1:0] DebounceReset = 16'd50;
   localparam logic [PeriodWidth-1:0] HoldReset     = 16'd300;
   localparam logic [PeriodWidth-1:0] DblTapReset   = 16'd250;

   typedef struct packed {
      logic [PeriodWidth-1:0] deglitch_period;
      logic [PeriodWidth-1:0] debounce_period;
      logic [PeriodWidth-1:0] hold_period;
      logic [PeriodWidth-1:0] dbl_tap_window;
      logic                   active_low;
   } cfg_type;

   typedef struct packed {
      logic                 previous_raw;
      logic [TimeWidth-1:0] stable_since;
      logic                 deglitched_level;
      logic                 debounced_level;
      logic [TimeWidth-1:0] last_change_time;
      logic [TimeWidth-1:0] last_push_time;
      logic [TimeWidth-1:0] last_release_time;
      logic                 one_tap_blocked;
      logic                 hold_blocked;
   } state_type;

   // Result flags, highest bit first as packed in rsp_tdata
   typedef struct packed {
      logic one_tap;
      logic dbl_tap;
      logic held_long;
      logic is_on;
      logic released;
      logic pushed;
      logic switched;
   } flags_type;

   localparam state_type StateReset = '{
      previous_raw:      1'b0,
      stable_since:      '0,
      deglitched_level:  1'b0,
      debounced_level:   1'b0,
      last_change_time:  '0,
      last_push_time:    '0,
      last_release_time: '0,
      one_tap_blocked:   1'b1,
      hold_blocked:      1'b0
   };

endpackage

// ===== hdl/sdcd_step.sv =====
// One poll of the debouncer: next state and event flags from current state.
// Depends on sdcd_pkg.
module sdcd_step import sdcd_pkg::*; (
   input  state_type            state,
   input  cfg_type              cfg,
   input  logic                 raw_level,
   input  logic [TimeWidth-1:0] time_ms,
   output state_type            state_next,
   output flags_type            flags
);

   logic [TimeWidth-1:0] dt_stable;
   logic [TimeWidth-1:0] dt_change;
   logic [TimeWidth-1:0] dt_push;
   logic [TimeWidth-1:0] press_len;
   logic [TimeWidth-1:0] deglitch_ext;
   logic [TimeWidth-1:0] debounce_ext;
   logic [TimeWidth-1:0] long_ext;
   logic [TimeWidth-1:0] dclick_ext;
   logic                 degl_level;
   logic                 sw;
   logic                 on;
   logic                 push;
   logic                 rel;
   logic                 near_push;
   logic                 sc_blocked;
   logic                 lp_blocked;
   logic                 sc;
   logic                 lp;

   assign deglitch_ext = {{(TimeWidth-PeriodWidth){1'b0}}, cfg.deglitch_period};
   assign debounce_ext = {{(TimeWidth-PeriodWidth){1'b0}}, cfg.debounce_period};
   assign long_ext     = {{(TimeWidth-PeriodWidth){1'b0}}, cfg.hold_period};
   assign dclick_ext   = {{(TimeWidth-PeriodWidth){1'b0}}, cfg.dbl_tap_window};

   assign dt_stable = time_ms - state.stable_since;
   assign dt_change = time_ms - state.last_change_time;
   assign dt_push   = time_ms - state.last_push_time;
   assign press_len = state.last_release_time - state.last_push_time;
   assign near_push = dt_push < dclick_ext;

   always_comb begin
      state_next = state;

      // deglitch
      degl_level = state.deglitched_level;
      if (raw_level != state.previous_raw) begin
         state_next.stable_since = time_ms;
      end else if (dt_stable > deglitch_ext) begin
         degl_level              = raw_level;
         state_next.stable_since = time_ms;
      end
      state_next.previous_raw     = raw_level;
      state_next.deglitched_level = degl_level;

      // debounce
      sw = (degl_level != state.debounced_level) && (dt_change > debounce_ext);
      state_next.debounced_level = sw ? degl_level : state.debounced_level;

      on   = (state_next.debounced_level == ~cfg.active_low);
      push = sw && on;
      rel  = sw && !on;

      // single click
      sc_blocked = push ? near_push : state.one_tap_blocked;
      sc = 1'b0;
      if (!sc_blocked) begin
         sc = !sw && !on && (press_len <= long_ext) && !near_push;
         sc_blocked = sc;
      end
      state_next.one_tap_blocked = sc_blocked;

      // long press
      lp_blocked = rel ? 1'b0 : state.hold_blocked;
      lp = 1'b0;
      if (!lp_blocked) begin
         lp = !sw && on && (dt_push > long_ext);
         lp_blocked = lp;
      end
      state_next.hold_blocked = lp_blocked;

      // timestamps
      if (sw) begin
         state_next.last_change_time = time_ms;
         if (push) begin
            state_next.last_push_time = time_ms;
         end else begin
            state_next.last_release_time = time_ms;
         end
      end

      flags.switched  = sw;
      flags.pushed    = push;
      flags.released  = rel;
      flags.is_on     = on;
      flags.held_long = lp;
      flags.dbl_tap   = push && near_push;
      flags.one_tap   = sc;
   end

endmodule

// ===== hdl/switch_debounce_click_detector_core.sv =====
// Top level of the switch debouncer with click and long-press detection.
// Depends on sdcd_pkg and sdcd_step.
//
//  Port group | Direction | Transaction carries
//  -----------+-----------+-------------------------------------------------
//  req_*      | in        | one poll: raw_level, time_ms
//  rsp_*      | out       | one result per poll: seven event/level flags
//  csr_*      | in        | register write: index, data
//
// One poll per cycle sustained while rsp_tready stays high. A poll is
// captured in the input register and then moves into the result register,
// which drives rsp_tvalid. The state update happens when a poll moves from
// the input register to the result register.
// Reset (synchronous, active high) empties both registers, restores the
// register defaults and the detector state. A stalled rsp holds the result
// and, once the input register is also full, drops req_tready.
module switch_debounce_click_detector_core import sdcd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // poll input
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [39:0]            req_tdata,  // [0] raw_level, [32:1] time_ms, [39:33] zero
   // result output
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,  // [0] switched, [1] pushed, [2] released,
                                              // [3] is_on, [4] held_long,
                                              // [5] dbl_tap, [6] one_tap, [7] zero
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [PeriodWidth-1:0] csr_data
);

   // input register
   logic                 in_valid_ff;
   logic                 in_raw_ff;
   logic [TimeWidth-1:0] in_time_ff;

   // result register
   logic                 out_valid_ff;
   flags_type            out_flags_ff;

   // detector state and configuration
   state_type            state_ff;
   state_type            state_in;
   cfg_type              cfg_ff;
   flags_type            flags_in;

   logic                 advance;
   logic                 req_take;
   logic                 csr_take;

   // a poll moves on when the result register is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // writes must only arrive while idle (the block does not enforce this); all are taken
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid;

   sdcd_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .raw_level  (in_raw_ff),
      .time_ms    (in_time_ff),
      .state_next (state_in),
      .flags      (flags_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_raw_ff  <= req_tdata[0];
         in_time_ff <= req_tdata[32:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateReset;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deglitch_period <= DeglitchReset;
         cfg_ff.debounce_period <= DebounceReset;
         cfg_ff.hold_period     <= HoldReset;
         cfg_ff.dbl_tap_window  <= DblTapReset;
         cfg_ff.active_low      <= 1'b0;
      end else if (csr_take) begin
         unique case (csr_index)
            CSR_DEGLITCH_PERIOD: cfg_ff.deglitch_period <= csr_data;
            CSR_DEBOUNCE_PERIOD: cfg_ff.debounce_period <= csr_data;
            CSR_HOLD_PERIOD:     cfg_ff.hold_period     <= csr_data;
            CSR_DBL_TAP_WINDOW:  cfg_ff.dbl_tap_window  <= csr_data;
            CSR_ACTIVE_LOW:      cfg_ff.active_low      <= csr_data[0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_flags_ff};

   // ---- checks ----

   // push and release are exclusive and both come from a debounced change
   a_edge_implies_switch: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_flags_ff.pushed || out_flags_ff.released) |->
         out_flags_ff.switched && !(out_flags_ff.pushed && out_flags_ff.released))
      else $error("push/release flag without a single debounced change");

   // a double click is always a push
   a_dclick_is_push: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_flags_ff.dbl_tap |-> out_flags_ff.pushed)
      else $error("double click without push");

   // long press only while held and steady; single click only while released
   a_lp_sc_level: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |->
         !(out_flags_ff.held_long && (!out_flags_ff.is_on || out_flags_ff.switched)) &&
         !(out_flags_ff.one_tap && (out_flags_ff.is_on || out_flags_ff.switched)))
      else $error("long press or single click on wrong level");

   // detector state only changes when a poll advances
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |-> $stable(state_ff))
      else $error("detector state changed without a poll");

endmodule
